FILE: rtl/core/sscnt_pkg.sv
// ----------------------------------------------------------------------------
// sscnt_pkg
// Shared types and constants for the subset counting table: field widths,
// operation codes and the request/response bundle of the modular reducer.
// ----------------------------------------------------------------------------
package sscnt_pkg;

    // Field widths of the stream payload
    localparam int FUNC_W     = 2;
    localparam int WEIGHT_W   = 11;
    localparam int QSIZE_W    = 6;
    localparam int QSUM_W     = 11;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 32;

    // Table entry width and the width of the sum of two entries
    localparam int CNT_W  = 30;
    localparam int SUM_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(SUM_W + 1);

    // Compare widths wide enough for the top of each parameter range
    localparam int SIZE_CMP_W = 8;
    localparam int SUM_CMP_W  = 16;

    // Default table shape
    localparam int MAX_SIZE_DEF = 63;
    localparam int MAX_SUM_DEF  = 2047;

    // Modulus register
    localparam logic [CNT_W-1:0] MOD_RESET = 30'd1000000007;
    localparam logic [CNT_W-1:0] MOD_MIN   = 30'd2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

    typedef struct packed {
        logic             start;
        logic             take;
        logic [SUM_W-1:0] value;
        logic [CNT_W-1:0] modulus;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } t_mod_rsp;

endpackage

FILE: rtl/core/sscnt_table_ram.sv
// ----------------------------------------------------------------------------
// sscnt_table_ram
// Count table storage: two synchronous read ports sharing one read enable,
// one write port. Read data is registered and holds while reads are off.
// ----------------------------------------------------------------------------
module sscnt_table_ram
    import sscnt_pkg::*;
#(
    parameter int AW = 17
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [CNT_W-1:0] o_rd_data_a,
    output logic [CNT_W-1:0] o_rd_data_b,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [CNT_W-1:0] i_wr_data
);

    logic [CNT_W-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

FILE: rtl/core/sscnt_mod_unit.sv
// ----------------------------------------------------------------------------
// sscnt_mod_unit
// Reduces a sum of two entries by the modulus. Values below twice the
// modulus resolve in the same cycle; others go through a restoring
// remainder loop, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sscnt_mod_unit
    import sscnt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_dvd;
    logic [STEP_W-1:0] r_cnt;

    logic [SUM_W:0]    d_one;
    logic [SUM_W:0]    d_two;
    logic              fast;
    logic [CNT_W-1:0]  fast_rem;
    logic [SUM_W-1:0]  trial;
    logic [SUM_W:0]    trial_diff;
    logic [CNT_W-1:0]  n_rem;

    // single compare-subtract when value < 2 * modulus
    assign d_one    = {1'b0, i_req.value} - {2'b00, i_req.modulus};
    assign d_two    = {1'b0, i_req.value} - {1'b0, i_req.modulus, 1'b0};
    assign fast     = d_two[SUM_W];
    assign fast_rem = d_one[SUM_W] ? i_req.value[CNT_W-1:0] : d_one[CNT_W-1:0];

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial      = {r_rem, r_dvd[SUM_W-1]};
    assign trial_diff = {1'b0, trial} - {2'b00, i_req.modulus};
    assign n_rem      = trial_diff[SUM_W] ? trial[CNT_W-1:0] : trial_diff[CNT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.start && !fast) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == STEP_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_req.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_rem <= '0;
            r_dvd <= i_req.value;
            r_cnt <= STEP_W'(SUM_W);
        end else if (r_state == ST_RUN) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_rsp.done = (r_state == ST_DONE) || ((r_state == ST_IDLE) && i_req.start && fast);
    assign o_rsp.rem  = (r_state == ST_DONE) ? r_rem : fast_rem;

endmodule

FILE: rtl/core/subset_count_by_size_and_sum.sv
// ----------------------------------------------------------------------------
// subset_count_by_size_and_sum
// Counts, modulo a programmable modulus, the subsets of the items added so
// far by subset size and weight sum, in a single table memory.
// ----------------------------------------------------------------------------
// Query: the entry is read from the memory, reduced and held in the result register.
// Add: weight w walks sums MAX_SUM down to w in rows MAX_SIZE down to 1,
//   one table entry per cycle through the memory's two read ports and one
//   write port while nothing stalls; an entry whose sum reaches twice the modulus stalls it in the reducer loop.
// Clear: one pass over all 2**(SW+TW) entries of the memory (131072 by default).
// Reset: the same clearing pass runs; modulus returns to 1000000007.
// ----------------------------------------------------------------------------
module subset_count_by_size_and_sum
    import sscnt_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF,
    parameter int MAX_SUM  = MAX_SUM_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [10:0] weight, [16:11] query_size, [27:17] query_sum, [31:28] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] func
    input  logic [FUNC_W-1:0]      s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [29:0] subset_count, [31:30] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // modulus write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CNT_W-1:0]       i_cfg_data
);

    localparam int SW = $clog2(MAX_SIZE + 1);
    localparam int TW = $clog2(MAX_SUM + 1);
    localparam int AW = SW + TW;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_QUERY = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    // Sequencer state
    logic [2:0]       r_state;
    logic [SW-1:0]    r_s;
    logic [TW-1:0]    r_t;
    logic [TW-1:0]    r_w;
    logic             r_qzero;
    logic [AW-1:0]    r_clr_addr;
    logic [CNT_W-1:0] r_modulus;

    // Pipeline: stage 1 waits on the memory, stage 2 reduces and writes back
    logic             r_v1;
    logic             r_q1;
    logic             r_z1;
    logic [AW-1:0]    r_addr1;
    logic             r_v2;
    logic             r_q2;
    logic [AW-1:0]    r_addr2;
    logic [SUM_W-1:0] r_sum2;

    // Result register
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_data;

    logic [FUNC_W-1:0]     in_func;
    logic [SUM_CMP_W-1:0]  in_weight;
    logic [SIZE_CMP_W-1:0] in_qsize;
    logic [SUM_CMP_W-1:0]  in_qsum;
    logic                  in_fire;
    logic                  weight_ok;
    logic                  query_ok;

    logic [CNT_W-1:0]  mod_eff;
    logic              out_room;
    logic              take;
    logic              advance;
    logic              s0_valid;
    logic              s0_query;
    logic [AW-1:0]     hi_addr;
    logic [AW-1:0]     lo_addr;
    logic [CNT_W-1:0]  q_hi;
    logic [CNT_W-1:0]  q_lo;
    logic [SUM_W-1:0]  sum1;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [CNT_W-1:0]  ram_wr_data;
    t_mod_req          mod_req;
    t_mod_rsp          mod_rsp;

    // ---- input beat decode (fields zero-extended to the compare widths)
    assign in_func   = s_axis_tuser;
    assign in_weight = SUM_CMP_W'(s_axis_tdata[10:0]);
    assign in_qsize  = SIZE_CMP_W'(s_axis_tdata[16:11]);
    assign in_qsum   = SUM_CMP_W'(s_axis_tdata[27:17]);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign weight_ok     = (in_weight <= SUM_CMP_W'(MAX_SUM));
    assign query_ok      = (in_qsize <= SIZE_CMP_W'(MAX_SIZE))
                        && (in_qsum <= SUM_CMP_W'(MAX_SUM));

    // The modulus port is always free; writes must come only while idle, which the block itself does not enforce
    assign o_cfg_ready = 1'b1;
    assign mod_eff     = (r_modulus < MOD_MIN) ? MOD_MIN : r_modulus;

    // ---- stall control
    // Stage 2 retires once the reducer has an answer and, for a query, the
    // result register has room. Until then everything upstream holds,
    // including the memory read data (read enable drops).
    assign out_room = !r_out_valid || m_axis_tready;
    assign take     = mod_rsp.done && (!r_q2 || out_room);
    assign advance  = !(r_v2 && !take);

    // ---- stage 0: address issue
    // Walking downward in size means row s-1 is still the old row when row
    // s reads it, and within a row the write trails the reads, so no entry
    // is read after it has been rewritten within the same add.
    assign s0_valid = (r_state == ST_ADD) || (r_state == ST_QUERY);
    assign s0_query = (r_state == ST_QUERY);
    assign hi_addr  = {r_s, r_t};
    assign lo_addr  = {r_s - SW'(1), r_t - r_w};

    sscnt_table_ram #(
        .AW (AW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rd_en     (advance),
        .i_rd_addr_a (hi_addr),
        .i_rd_addr_b (lo_addr),
        .o_rd_data_a (q_hi),
        .o_rd_data_b (q_lo),
        .i_wr_en     (ram_wr_en),
        .i_wr_addr   (ram_wr_addr),
        .i_wr_data   (ram_wr_data)
    );

    // ---- stage 1: form the sum; a query passes its entry, or zero if the
    // requested size or sum lies outside the table
    always_comb begin
        if (r_q1) begin
            sum1 = r_z1 ? '0 : {1'b0, q_hi};
        end else begin
            sum1 = {1'b0, q_hi} + {1'b0, q_lo};
        end
    end

    // ---- stage 2: reduce
    assign mod_req.start   = r_v2;
    assign mod_req.take    = take;
    assign mod_req.value   = r_sum2;
    assign mod_req.modulus = mod_eff;

    sscnt_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // Write port: the clearing pass owns it, otherwise add write-back
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = (r_clr_addr == '0) ? CNT_W'(1) : '0;
        end else begin
            ram_wr_en   = r_v2 && take && !r_q2;
            ram_wr_addr = r_addr2;
            ram_wr_data = mod_rsp.rem;
        end
    end

    // ---- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_modulus   <= MOD_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_modulus <= i_cfg_data;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (&r_clr_addr) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_fire) begin
                        case (in_func)
                            FN_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= ST_CLEAR;
                            end
                            FN_ADD: begin
                                // a weight above the last column changes nothing
                                if (weight_ok) begin
                                    r_state <= ST_ADD;
                                end
                            end
                            FN_QUERY: begin
                                r_state <= ST_QUERY;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ADD: begin
                    if (advance && (r_t == r_w) && (r_s == SW'(1))) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_QUERY: begin
                    if (advance) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase

            if (advance) begin
                r_v1 <= s0_valid;
                r_v2 <= r_v1;
            end

            if (take && r_q2) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (in_func == FN_ADD) begin
                r_s <= SW'(MAX_SIZE);
                r_t <= TW'(MAX_SUM);
                r_w <= in_weight[TW-1:0];
            end else begin
                r_s     <= query_ok ? in_qsize[SW-1:0] : '0;
                r_t     <= query_ok ? in_qsum[TW-1:0] : '0;
                r_qzero <= !query_ok;
            end
        end else if ((r_state == ST_ADD) && advance) begin
            // step down the sum, then down a row
            if (r_t == r_w) begin
                r_s <= r_s - SW'(1);
                r_t <= TW'(MAX_SUM);
            end else begin
                r_t <= r_t - TW'(1);
            end
        end

        if (advance) begin
            r_q1    <= s0_query;
            r_z1    <= r_qzero;
            r_addr1 <= hi_addr;
            r_q2    <= r_q1;
            r_addr2 <= r_addr1;
            r_sum2  <= sum1;
        end

        if (take && r_q2) begin
            r_out_data <= mod_rsp.rem;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    // ---- checks
    // Idle means the pipeline has fully drained
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_v1 && !r_v2))
        else $error("pipeline busy while accepting beats");

    // No table write while a new beat may be taken
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> !s_axis_tready)
        else $error("table written while idle");

    // The reducer answers only for a live stage-2 entry
    a_done_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_rsp.done |-> r_v2)
        else $error("reducer done without a request");

    // A stalled stage 2 keeps its entry
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !take) |=> (r_v2 && $stable(r_addr2) && $stable(r_sum2)))
        else $error("stage 2 lost its entry during a stall");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the subset counting table. A scoreboard class keeps
// its own copy of the count table and the modulus, predicts the count of
// every query beat and compares it with the result stream. Directed beats
// cover the extremes of each field and every operation. Random phases follow
// under several moduli and sender/receiver idling mixes, then a burst that
// runs into a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import sscnt_pkg::*;

    // func code that the block must ignore
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 12;
    localparam int BURST_ITEMS  = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    // Modulus per random phase: top of range, small prime, zero (taken as
    // two), the reset value and one (taken as two)
    localparam logic [CNT_W-1:0] PHASE_MOD [NUM_PHASES] =
        '{30'h3FFF_FFFF, 30'd13, 30'd0, 30'd1000000007, 30'd1};
    // Percentage of cycles the sender idles and the receiver stalls
    localparam int PHASE_SRC_IDLE [NUM_PHASES]  = '{0, 79, 0, 27, 0};
    localparam int PHASE_SINK_STALL [NUM_PHASES] = '{0, 0, 79, 27, 0};

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the count table and of the modulus
    // ------------------------------------------------------------------------
    class subset_tally;
        logic [CNT_W-1:0] cnt_tab [0:MAX_SIZE_DEF][0:MAX_SUM_DEF];
        logic [CNT_W-1:0] modulus;
        logic [CNT_W-1:0] expected_counts [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      n_adds;
        int unsigned      n_queries;
        int unsigned      n_clears;

        function new();
            modulus = MOD_RESET;
            restore_start_table();
        endfunction

        function void restore_start_table();
            foreach (cnt_tab[s, t]) cnt_tab[s][t] = '0;
            cnt_tab[0][0] = CNT_W'(1);
        endfunction

        // Zero and one behave as two
        function longint unsigned eff_modulus();
            return (modulus < MOD_MIN) ? longint'(MOD_MIN) : longint'(modulus);
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [WEIGHT_W-1:0] weight,
                                   logic [QSIZE_W-1:0] qsize, logic [QSUM_W-1:0] qsum);
            longint unsigned  m;
            longint unsigned  v;
            int               w;
            logic [CNT_W-1:0] want;
            m = eff_modulus();
            w = int'(weight);
            case (func)
                FN_CLEAR: begin
                    restore_start_table();
                    n_clears++;
                end
                FN_ADD: begin
                    // walk downward so each entry sees the row below unchanged
                    for (int s = MAX_SIZE_DEF; s >= 1; s--) begin
                        for (int t = MAX_SUM_DEF; t >= w; t--) begin
                            v = longint'(cnt_tab[s][t]) + longint'(cnt_tab[s-1][t-w]);
                            cnt_tab[s][t] = CNT_W'(v % m);
                        end
                    end
                    n_adds++;
                end
                FN_QUERY: begin
                    want = CNT_W'(longint'(cnt_tab[qsize][qsum]) % m);
                    expected_counts = {expected_counts, want};
                    n_queries++;
                end
                default: ;
            endcase
        endfunction

        function void check_count(logic [CNT_W-1:0] got);
            logic [CNT_W-1:0] want;
            if (expected_counts.size() == 0) begin
                $error("subset_count: no result expected, got %0d", got);
                mismatches++;
            end else begin
                want = expected_counts.pop_front();
                checked++;
                if (got !== want) begin
                    $error("subset_count: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its stimulus
    // ------------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [FUNC_W-1:0]      s_axis_tuser  = FN_QUERY;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data    = '0;

    subset_tally tally = new();

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    logic sink_hold    = 1'b0;

    // Weights added since the last clear; steer queries towards live entries
    int added_weights [$];

    subset_count_by_size_and_sum dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: check every beat taken at the edge, then pick the next ready
    initial begin
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                tally.check_count(m_axis_tdata[CNT_W-1:0]);
            if (sink_hold)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #1_000_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one beat after a random idle gap; return once it has been taken
    task automatic send_beat(logic [FUNC_W-1:0] func, int w, int qs, int qt);
        logic [WEIGHT_W-1:0] wv;
        logic [QSIZE_W-1:0]  qsv;
        logic [QSUM_W-1:0]   qtv;
        wv  = WEIGHT_W'(w);
        qsv = QSIZE_W'(qs);
        qtv = QSUM_W'(qt);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {{(IN_TDATA_W-QSUM_W-QSIZE_W-WEIGHT_W){1'b0}}, qtv, qsv, wv};
        do @(posedge i_clk); while (!s_axis_tready);
        tally.note_request(func, wv, qsv, qtv);
        if (func == FN_ADD)
            added_weights = {added_weights, w};
        else if (func == FN_CLEAR)
            added_weights.delete();
    endtask

    // Query either a random entry or one reachable from the weights added
    task automatic send_query_near_data();
        int k;
        int sum;
        if ($urandom_range(1) == 0 || added_weights.size() == 0) begin
            send_beat(FN_QUERY, 0, $urandom_range(63), $urandom_range(2047));
        end else begin
            k   = $urandom_range(2);
            sum = 0;
            repeat (k) sum += added_weights[$urandom_range(added_weights.size() - 1)];
            send_beat(FN_QUERY, 0, k, sum % 2048);
        end
    endtask

    // Drop valid and hold until every expected count has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tally.expected_counts.size() != 0);
    endtask

    task automatic write_modulus(logic [CNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tally.modulus = value;
    endtask

    task automatic hold_receiver(int cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        sink_hold <= 1'b0;
    endtask

    initial begin
        int n;
        int r;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset modulus; the block clears itself first
        send_beat(FN_QUERY,  0,    0,  0);      // start table: one at origin
        send_beat(FN_QUERY,  0,    63, 2047);   // far corner is empty
        send_beat(FN_UNUSED, 2047, 63, 2047);   // unused code, all ones
        send_beat(FN_ADD,    2047, 0,  0);      // heaviest weight that fits
        send_beat(FN_QUERY,  0,    1,  2047);
        send_beat(FN_ADD,    0,    0,  0);      // weightless item: longest walk
        send_beat(FN_QUERY,  0,    1,  0);
        send_beat(FN_QUERY,  0,    2,  2047);
        send_beat(FN_QUERY,  0,    1,  2047);
        send_beat(FN_ADD,    1024, 0,  0);
        send_beat(FN_ADD,    1023, 0,  0);      // pair lands on the last column
        send_beat(FN_QUERY,  0,    2,  2047);
        send_beat(FN_QUERY,  0,    3,  2047);
        send_beat(FN_QUERY,  0,    1,  1024);
        send_beat(FN_QUERY,  0,    2,  1024);
        send_beat(FN_CLEAR,  0,    0,  0);      // back to the start table
        send_beat(FN_QUERY,  0,    0,  0);
        send_beat(FN_QUERY,  0,    1,  1024);
        send_beat(FN_ADD,    2047, 0,  0);
        send_beat(FN_UNUSED, 0,    0,  0);      // unused code, all zeros
        send_beat(FN_QUERY,  0,    1,  2047);
        wait_drained();

        // Random phases, each under its own modulus and idling mix
        for (int p = 0; p < NUM_PHASES; p++) begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
            repeat (8) @(posedge i_clk);
            write_modulus(PHASE_MOD[p]);
            src_idle_pct   = PHASE_SRC_IDLE[p];
            sink_stall_pct = PHASE_SINK_STALL[p];
            // clear under a non-default modulus: the modulus must survive it
            if (p == NUM_PHASES - 1)
                send_beat(FN_CLEAR, 0, 0, 0);
            n = 0;
            while (n < PHASE_ITEMS) begin
                // pause once per phase until the block has caught up
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                r = $urandom_range(99);
                if (n == PHASE_ITEMS - 1) begin
                    // close on a query so its count marks the block idle
                    send_query_near_data();
                    n++;
                end else if (r < 4) begin
                    send_beat(FN_UNUSED, $urandom_range(2047), $urandom_range(63),
                              $urandom_range(2047));
                end else if (r < 28) begin
                    // mostly heavy items, which walk only a short tail of the table
                    if ($urandom_range(7) == 0)
                        send_beat(FN_ADD, $urandom_range(1000, 1300), 0, 0);
                    else
                        send_beat(FN_ADD, $urandom_range(1800, 2047), 0, 0);
                    n++;
                end else begin
                    send_query_near_data();
                    n++;
                end
            end
            wait_drained();
        end

        // Back-to-back queries into a receiver held off for a long stretch
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        fork
            hold_receiver(HOLD_CYCLES);
        join_none
        repeat (BURST_ITEMS) send_query_near_data();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tally.expected_counts.size() != 0) begin
            $error("subset_count: %0d results never arrived", tally.expected_counts.size());
            tally.mismatches++;
        end
        $display("Covered %0d adds, %0d queries and %0d clears under five moduli,",
                 tally.n_adds, tally.n_queries, tally.n_clears);
        $display("four idling mixes and a long receiver hold-off; %0d counts checked.",
                 tally.checked);
        if (tally.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
